@@ rtl/core/tps_pkg.sv @@
package tps_pkg;

  localparam int unsigned TimerW  = 16;
  localparam int unsigned StableW = 17;
  localparam int unsigned RetryW  = 4;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [TimerW-1:0]  TimerMax  = '1;
  localparam logic [StableW-1:0] StableMax = '1;

  localparam logic [TimerW-1:0] TapTicksRst      = TimerW'(100);
  localparam logic [TimerW-1:0] GapTicksRst      = TimerW'(150);
  localparam logic [TimerW-1:0] SettleTicksRst   = TimerW'(180);
  localparam logic [TimerW-1:0] DebounceTicksRst = TimerW'(50);
  localparam logic [RetryW-1:0] MaxRetriesRst    = RetryW'(4);

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_ON   = 2'd1,
    REQ_OFF  = 2'd2,
    REQ_TAP  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_GAP    = 2'd2,
    PH_VERIFY = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TAP_TICKS      = 3'd0,
    CFG_GAP_TICKS      = 3'd1,
    CFG_SETTLE_TICKS   = 3'd2,
    CFG_DEBOUNCE_TICKS = 3'd3,
    CFG_MAX_RETRIES    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TimerW-1:0] tap_ticks;
    logic [TimerW-1:0] gap_ticks;
    logic [TimerW-1:0] settle_ticks;
    logic [RetryW-1:0] max_retries;
  } seq_cfg_t;

  typedef struct packed {
    logic   touch;
    phase_e phase;
    logic   gave_up;
    logic   publish;
  } seq_res_t;

endpackage

@@ rtl/core/tps_sense.sv @@
module tps_sense
  import tps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              raw_i,
  input  logic [TimerW-1:0] debounce_ticks_i,
  output logic              lamp_o,
  output logic              changed_o
);

  logic               last_raw_q;
  logic [StableW-1:0] stable_q, stable_d;
  logic               lamp_q, lamp_d;

  always_comb begin
    if (raw_i != last_raw_q) begin
      stable_d = '0;
    end else if (stable_q != StableMax) begin
      stable_d = stable_q + StableW'(1);
    end else begin
      stable_d = stable_q;
    end
    lamp_d    = lamp_q;
    changed_o = 1'b0;
    // led lit means lamp off
    if (stable_d > {1'b0, debounce_ticks_i} && (~raw_i != lamp_q)) begin
      lamp_d    = ~raw_i;
      changed_o = 1'b1;
    end
  end

  assign lamp_o = lamp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b1;
      stable_q   <= '0;
      lamp_q     <= 1'b0;
    end else if (en_i) begin
      last_raw_q <= raw_i;
      stable_q   <= stable_d;
      lamp_q     <= lamp_d;
    end
  end

endmodule

@@ rtl/core/tps_seq.sv @@
module tps_seq
  import tps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  req_e     req_i,
  input  logic     raw_i,
  input  seq_cfg_t cfg_i,
  output seq_res_t res_o
);

  phase_e            phase_q, phase_d;
  logic [1:0]        taps_q, taps_d;
  logic              verify_q, verify_d;
  logic [RetryW-1:0] retry_q, retry_d;
  logic [TimerW-1:0] timer_q, timer_d, timer_inc;
  logic              touch_q, touch_d;
  logic              gave_up, redundant;
  logic              start;
  logic [1:0]        start_taps;
  logic              start_verify;

  assign timer_inc = (timer_q != TimerMax) ? timer_q + TimerW'(1) : timer_q;

  always_comb begin
    phase_d      = phase_q;
    taps_d       = taps_q;
    verify_d     = verify_q;
    retry_d      = retry_q;
    timer_d      = timer_q;
    touch_d      = touch_q;
    gave_up      = 1'b0;
    redundant    = 1'b0;
    start        = 1'b0;
    start_taps   = 2'd0;
    start_verify = 1'b0;

    // one tick of the running sequence
    if (phase_q != PH_IDLE) begin
      timer_d = timer_inc;
      case (phase_q)
        PH_ACTIVE: begin
          if (timer_inc >= cfg_i.tap_ticks) begin
            touch_d = 1'b0;
            timer_d = '0;
            if (taps_q > 2'd1) begin
              taps_d  = taps_q - 2'd1;
              phase_d = PH_GAP;
            end else begin
              taps_d  = 2'd0;
              phase_d = verify_q ? PH_VERIFY : PH_IDLE;
            end
          end
        end
        PH_GAP: begin
          if (timer_inc >= cfg_i.gap_ticks) begin
            touch_d = 1'b1;
            phase_d = PH_ACTIVE;
            timer_d = '0;
          end
        end
        PH_VERIFY: begin
          if (timer_inc >= cfg_i.settle_ticks) begin
            if (raw_i) begin
              phase_d  = PH_IDLE;
              verify_d = 1'b0;
            end else if (retry_q < cfg_i.max_retries) begin
              // corrective single tap
              retry_d = retry_q + RetryW'(1);
              taps_d  = 2'd1;
              phase_d = PH_ACTIVE;
              timer_d = '0;
              touch_d = 1'b1;
            end else begin
              phase_d  = PH_IDLE;
              verify_d = 1'b0;
              gave_up  = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // command, judged on the raw level
    case (req_i)
      REQ_ON: begin
        if (!raw_i) begin
          redundant = 1'b1;
        end else begin
          start      = 1'b1;
          start_taps = 2'd2;
        end
      end
      REQ_OFF: begin
        if (raw_i) begin
          redundant = 1'b1;
        end else begin
          start        = 1'b1;
          start_taps   = 2'd2;
          start_verify = 1'b1;
        end
      end
      REQ_TAP: begin
        start      = 1'b1;
        start_taps = 2'd1;
      end
      default: ;
    endcase

    if (start) begin
      taps_d   = start_taps;
      verify_d = start_verify;
      retry_d  = '0;
      phase_d  = PH_ACTIVE;
      timer_d  = '0;
      touch_d  = 1'b1;
    end
  end

  assign res_o.touch   = touch_d;
  assign res_o.phase   = phase_d;
  assign res_o.gave_up = gave_up;
  assign res_o.publish = redundant;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      taps_q   <= 2'd0;
      verify_q <= 1'b0;
      retry_q  <= '0;
      timer_q  <= '0;
      touch_q  <= 1'b0;
    end else if (en_i) begin
      phase_q  <= phase_d;
      taps_q   <= taps_d;
      verify_q <= verify_d;
      retry_q  <= retry_d;
      timer_q  <= timer_d;
      touch_q  <= touch_d;
    end
  end

endmodule

@@ rtl/core/touch_pulse_sequencer_verify.sv @@
// flow: an item is held in the input register, its result in the result register
// throughput: one item per cycle while results drain; sequencer and debounce state
// update as an item moves from the input register to the result register
// reset: asynchronous active low; registers return to their defaults, lamp off,
// touch output low, led level assumed lit, both channel registers empty
module touch_pulse_sequencer_verify
  import tps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // slave side
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // [0] sense_raw, rest zero
  input  logic [1:0]         s_axis_tuser,  // [1:0] req_type
  // master side
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [0] touch_drive, [1] lamp_on, [2] busy_res, [3] publish, [4] gave_up,
  // [6:5] phase, [7] zero
  output logic [7:0]         m_axis_tdata,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimerW-1:0]  cfg_data_i
);

  logic              in_valid_q;
  req_e              req_q;
  logic              raw_q;
  logic              out_valid_q;
  logic [7:0]        out_data_q, out_data_d;
  logic              advance;
  logic              lamp, sense_changed;
  seq_cfg_t          seq_cfg;
  seq_res_t          seq_res;
  logic [TimerW-1:0] tap_ticks_q, gap_ticks_q, settle_ticks_q, debounce_ticks_q;
  logic [RetryW-1:0] max_retries_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_ticks_q      <= TapTicksRst;
      gap_ticks_q      <= GapTicksRst;
      settle_ticks_q   <= SettleTicksRst;
      debounce_ticks_q <= DebounceTicksRst;
      max_retries_q    <= MaxRetriesRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TAP_TICKS:      tap_ticks_q      <= cfg_data_i;
        CFG_GAP_TICKS:      gap_ticks_q      <= cfg_data_i;
        CFG_SETTLE_TICKS:   settle_ticks_q   <= cfg_data_i;
        CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data_i;
        CFG_MAX_RETRIES:    max_retries_q    <= cfg_data_i[RetryW-1:0];
        default: ;
      endcase
    end
  end

  // the held item moves on whenever the result register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q <= req_e'(s_axis_tuser);
      raw_q <= s_axis_tdata[0];
    end
  end

  assign seq_cfg.tap_ticks    = tap_ticks_q;
  assign seq_cfg.gap_ticks    = gap_ticks_q;
  assign seq_cfg.settle_ticks = settle_ticks_q;
  assign seq_cfg.max_retries  = max_retries_q;

  tps_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (req_q),
    .raw_i  (raw_q),
    .cfg_i  (seq_cfg),
    .res_o  (seq_res)
  );

  tps_sense u_sense (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (advance),
    .raw_i            (raw_q),
    .debounce_ticks_i (debounce_ticks_q),
    .lamp_o           (lamp),
    .changed_o        (sense_changed)
  );

  assign out_data_d = {1'b0, seq_res.phase, seq_res.gave_up,
                       seq_res.publish | sense_changed,
                       seq_res.phase != PH_IDLE, lamp, seq_res.touch};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/core/tps_checker.sv @@
module tps_checker
  import tps_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // busy flag agrees with the reported phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[6:5] != PH_IDLE)))
    else $error("busy_res disagrees with phase");

  // the touch output is high exactly while a pulse is active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[6:5] == PH_ACTIVE)))
    else $error("touch_drive disagrees with pulse phase");

  // input only stalls behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result transfer changed");

endmodule

bind touch_pulse_sequencer_verify tps_checker u_tps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/touch_pulse_sequencer_verify_tb.sv @@
`timescale 1ns / 100ps

module touch_pulse_sequencer_verify_tb;
  import tps_pkg::*;

  typedef struct {
    req_e req;
    logic raw;
  } touch_req_t;

  typedef struct {
    logic   touch;
    logic   lamp;
    logic   busy;
    logic   publish;
    logic   gave_up;
    phase_e phase;
  } lamp_status_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;   // [0] sense_raw, [7:1] zero
  logic [1:0]         s_axis_tuser = '0;   // [1:0] req_type
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // [0] touch_drive, [1] lamp_on, [2] busy_res, [3] publish, [4] gave_up,
  // [6:5] phase, [7] zero
  logic [7:0]         m_axis_tdata;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [TimerW-1:0]  cfg_data_i = '0;

  touch_pulse_sequencer_verify u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // pending stimulus and expected status words
  touch_req_t   cmd_q[$];
  lamp_status_t status_q[$];

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  logic        in_fire = 1'b0;
  logic        sense_level = 1'b1;

  int unsigned n_err = 0;
  int unsigned n_items = 0;
  int unsigned n_checked = 0;
  int unsigned n_cmds = 0;
  int unsigned n_gave_up = 0;
  int unsigned n_publish = 0;
  int unsigned n_cfg = 0;

  // predictor copy of registers and state
  logic [TimerW-1:0]  m_tap = TapTicksRst;
  logic [TimerW-1:0]  m_gap = GapTicksRst;
  logic [TimerW-1:0]  m_settle = SettleTicksRst;
  logic [TimerW-1:0]  m_debounce = DebounceTicksRst;
  logic [RetryW-1:0]  m_retries = MaxRetriesRst;

  phase_e             seq_ph = PH_IDLE;
  logic [1:0]         taps = '0;
  logic               verify_due = 1'b0;
  logic [RetryW-1:0]  retry_cnt = '0;
  logic [TimerW-1:0]  ph_timer = '0;
  logic               touch_lvl = 1'b0;
  logic               prev_raw = 1'b1;
  logic [StableW-1:0] stable_cnt = '0;
  logic               lamp = 1'b0;

  function automatic void begin_pulses(logic [1:0] n, logic verify);
    taps       = n;
    verify_due = verify;
    retry_cnt  = '0;
    seq_ph     = PH_ACTIVE;
    ph_timer   = '0;
    touch_lvl  = 1'b1;
  endfunction

  function automatic lamp_status_t lamp_ctl_step(req_e req, logic raw);
    lamp_status_t r;
    logic failed;
    logic publish;
    failed  = 1'b0;
    publish = 1'b0;
    if (seq_ph != PH_IDLE) begin
      if (ph_timer != TimerMax) ph_timer = ph_timer + 1'b1;
      case (seq_ph)
        PH_ACTIVE: begin
          if (ph_timer >= m_tap) begin
            touch_lvl = 1'b0;
            ph_timer  = '0;
            if (taps > 2'd1) begin
              taps   = taps - 1'b1;
              seq_ph = PH_GAP;
            end else begin
              taps   = '0;
              seq_ph = verify_due ? PH_VERIFY : PH_IDLE;
            end
          end
        end
        PH_GAP: begin
          if (ph_timer >= m_gap) begin
            touch_lvl = 1'b1;
            seq_ph    = PH_ACTIVE;
            ph_timer  = '0;
          end
        end
        default: begin
          if (ph_timer >= m_settle) begin
            if (raw) begin
              seq_ph     = PH_IDLE;
              verify_due = 1'b0;
            end else if (retry_cnt < m_retries) begin
              // lamp still on: one corrective tap, then check again
              retry_cnt = retry_cnt + 1'b1;
              taps      = 2'd1;
              seq_ph    = PH_ACTIVE;
              ph_timer  = '0;
              touch_lvl = 1'b1;
            end else begin
              seq_ph     = PH_IDLE;
              verify_due = 1'b0;
              failed     = 1'b1;
            end
          end
        end
      endcase
    end

    if (raw != prev_raw) begin
      prev_raw   = raw;
      stable_cnt = '0;
    end else if (stable_cnt != StableMax) begin
      stable_cnt = stable_cnt + 1'b1;
    end
    if (stable_cnt > StableW'(m_debounce) && (~raw) != lamp) begin
      lamp    = ~raw;
      publish = 1'b1;
    end

    // redundant on/off judged on the raw level of this item
    case (req)
      REQ_ON:  if (!raw) publish = 1'b1; else begin_pulses(2'd2, 1'b0);
      REQ_OFF: if (raw) publish = 1'b1; else begin_pulses(2'd2, 1'b1);
      REQ_TAP: begin_pulses(2'd1, 1'b0);
      default: ;
    endcase

    r.touch   = touch_lvl;
    r.lamp    = lamp;
    r.busy    = (seq_ph != PH_IDLE);
    r.publish = publish;
    r.gave_up = failed;
    r.phase   = seq_ph;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      n_err++;
    end
  endtask

  // monitor: register writes, accepted commands and returned status words
  always @(posedge clk_i) begin
    lamp_status_t e;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      n_cfg++;
      case (cfg_idx_e'(cfg_index_i))
        CFG_TAP_TICKS:      m_tap = cfg_data_i;
        CFG_GAP_TICKS:      m_gap = cfg_data_i;
        CFG_SETTLE_TICKS:   m_settle = cfg_data_i;
        CFG_DEBOUNCE_TICKS: m_debounce = cfg_data_i;
        CFG_MAX_RETRIES:    m_retries = cfg_data_i[RetryW-1:0];
        default: ;
      endcase
    end

    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (status_q.size() == 0) begin
        $error("status transfer with nothing expected: %h", m_axis_tdata);
        n_err++;
      end else begin
        e = status_q.pop_front();
        n_checked++;
        check_field("touch_drive", e.touch, m_axis_tdata[0]);
        check_field("lamp_on", e.lamp, m_axis_tdata[1]);
        check_field("busy_res", e.busy, m_axis_tdata[2]);
        check_field("publish", e.publish, m_axis_tdata[3]);
        check_field("gave_up", e.gave_up, m_axis_tdata[4]);
        check_field("phase", e.phase, m_axis_tdata[6:5]);
        check_field("pad", 0, m_axis_tdata[7]);
        if (e.gave_up) n_gave_up++;
        if (e.publish) n_publish++;
      end
    end

    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      n_items++;
      if (req_e'(s_axis_tuser) != REQ_TICK) n_cmds++;
      status_q.push_back(lamp_ctl_step(req_e'(s_axis_tuser), s_axis_tdata[0]));
    end
  end

  // driver: one item held until its transfer, random gaps and stalls
  always @(negedge clk_i) begin
    touch_req_t it;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          it = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, it.raw};
          s_axis_tuser  <= it.req;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic push_cmd(req_e req, logic raw);
    touch_req_t it;
    it.req = req;
    it.raw = raw;
    cmd_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || s_axis_tvalid || status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= TimerW'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_regs(int unsigned tap, int unsigned gap, int unsigned settle,
                           int unsigned deb, int unsigned retries);
    wait_idle();
    write_reg(CFG_TAP_TICKS, tap);
    write_reg(CFG_GAP_TICKS, gap);
    write_reg(CFG_SETTLE_TICKS, settle);
    write_reg(CFG_DEBOUNCE_TICKS, deb);
    write_reg(CFG_MAX_RETRIES, retries);
  endtask

  task automatic set_idle(int unsigned mode);
    case (mode % 4)
      0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin snd_idle_pct = 45; rcv_stall_pct = 0;  end
      2: begin snd_idle_pct = 0;  rcv_stall_pct = 45; end
      default: begin snd_idle_pct = 17; rcv_stall_pct = 17; end
    endcase
  endtask

  // mostly a command followed by a run of ticks with a slowly moving sense
  // level; the rest is noise with random commands and levels
  task automatic queue_random(int unsigned n);
    int unsigned cnt;
    int unsigned run;
    cnt = 0;
    while (cnt < n) begin
      run = $urandom_range(60, 3);
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(99) < 30) sense_level = ~sense_level;
        push_cmd(req_e'($urandom_range(3, 1)), sense_level);
        repeat (run) begin
          if ($urandom_range(99) < 5) sense_level = ~sense_level;
          push_cmd(REQ_TICK, sense_level);
        end
      end else begin
        repeat (run) begin
          sense_level = 1'($urandom_range(1));
          push_cmd(req_e'($urandom_range(99) < 70 ? 0 : $urandom_range(3)), sense_level);
        end
      end
      cnt += run + 1;
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: redundant on and off, starting on, tap restart
    push_cmd(REQ_TICK, 1'b1);
    push_cmd(REQ_ON, 1'b0);
    push_cmd(REQ_OFF, 1'b1);
    push_cmd(REQ_ON, 1'b1);
    push_cmd(REQ_TICK, 1'b1);
    push_cmd(REQ_TAP, 1'b1);
    push_cmd(REQ_TICK, 1'b0);
    push_cmd(REQ_TICK, 1'b0);

    // shortest timings, no retries: off check fails at once
    load_regs(1, 1, 1, 0, 0);
    push_cmd(REQ_OFF, 1'b0);
    repeat (6) push_cmd(REQ_TICK, 1'b0);

    // two retries, lamp goes off during the second
    load_regs(1, 1, 1, 0, 2);
    push_cmd(REQ_OFF, 1'b0);
    repeat (7) push_cmd(REQ_TICK, 1'b0);
    repeat (3) push_cmd(REQ_TICK, 1'b1);
    push_cmd(REQ_ON, 1'b1);
    push_cmd(REQ_OFF, 1'b0);

    load_regs(1, 1, 1, 0, 0);
    set_idle(0);
    queue_random(200);
    load_regs(3, 2, 5, 3, 4);
    set_idle(1);
    queue_random(250);
    load_regs(2, 4, 8, 6, 15);
    set_idle(2);
    queue_random(250);
    load_regs(65535, 65535, 65535, 65535, 15);
    set_idle(3);
    queue_random(60);
    for (int p = 0; p < 2; p++) begin
      load_regs($urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(12, 1),
                $urandom_range(8, 0), $urandom_range(5, 0));
      set_idle(p + 1);
      queue_random(220);
    end

    wait_idle();
    set_idle(0);
    repeat (10) @(posedge clk_i);
    $display("items %0d (commands %0d), status words checked %0d, register writes %0d",
             n_items, n_cmds, n_checked, n_cfg);
    $display("give-ups %0d, publish reports %0d, mismatches %0d",
             n_gave_up, n_publish, n_err);
    if (n_err == 0 && status_q.size() == 0) begin
      $display("touch_pulse_sequencer_verify_tb: done, clean");
    end else begin
      $display("touch_pulse_sequencer_verify_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout: %0d status words still expected", status_q.size());
    $display("touch_pulse_sequencer_verify_tb: done, errors");
    $finish;
  end

endmodule
